// ===== hdl/lpe_pkg.sv =====
// ============================================================================
// Legendre polynomial evaluator package
// Shared widths, microcode control word, microcode program and helpers for
// the Legendre polynomial evaluator.
// ============================================================================
package lpe_pkg;

    // Fixed field widths and default parameter values.
    localparam int DATA_W     = 16;
    localparam int DEG_W      = 5;
    localparam int MAX_DEGREE = 31;
    localparam int FRAC_BITS  = 14;

    // Fraction bits of the 1/k reciprocal table.
    localparam int RECIP_BITS = 24;

    // Step counter width and the addresses of the microcode program.
    localparam int PC_W = 3;
    localparam logic [PC_W-1:0] PC_MUL_XP  = 3'd0;
    localparam logic [PC_W-1:0] PC_MUL_ODD = 3'd1;
    localparam logic [PC_W-1:0] PC_SUB     = 3'd2;
    localparam logic [PC_W-1:0] PC_RND     = 3'd3;
    localparam logic [PC_W-1:0] PC_CLIP    = 3'd4;

    // Multiplier operand A source.
    typedef enum logic [1:0] {
        A_X,
        A_ACC,
        A_P2
    } t_asel;

    // Multiplier operand B source.
    typedef enum logic [1:0] {
        B_P1,
        B_ODD,
        B_KM1,
        B_RECIP
    } t_bsel;

    // Accumulator update.
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_MUL,
        ACC_SUB,
        ACC_RND
    } t_accop;

    // Sequencing after a step.
    typedef enum logic {
        J_NEXT,
        J_LOOP
    } t_jump;

    // One microcode control word.
    typedef struct packed {
        t_asel  asel;
        t_bsel  bsel;
        t_accop accop;
        logic   wb;
        t_jump  jump;
    } t_ctrl;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     sat;
    } t_dp_stat;

    localparam t_ctrl CTRL_NOP = '{A_X, B_P1, ACC_HOLD, 1'b0, J_NEXT};

    // Microcode program: one recurrence step k in five words.
    function automatic t_ctrl ucode(input logic [PC_W-1:0] pc);
        t_ctrl w;
        case (pc)
            PC_MUL_XP:  w = '{A_X,   B_P1,    ACC_MUL,  1'b0, J_NEXT};
            PC_MUL_ODD: w = '{A_ACC, B_ODD,   ACC_MUL,  1'b0, J_NEXT};
            PC_SUB:     w = '{A_P2,  B_KM1,   ACC_SUB,  1'b0, J_NEXT};
            PC_RND:     w = '{A_ACC, B_RECIP, ACC_RND,  1'b0, J_NEXT};
            PC_CLIP:    w = '{A_X,   B_P1,    ACC_HOLD, 1'b1, J_LOOP};
            default:    w = CTRL_NOP;
        endcase
        return w;
    endfunction

    // True when the value one does not fit the signed 16-bit result.
    function automatic logic one_sat(input int frac);
        return (frac >= DATA_W - 1);
    endfunction

    // The value one, clipped to the signed 16-bit range.
    function automatic logic signed [DATA_W-1:0] one_value(input int frac);
        logic signed [DATA_W-1:0] v;
        if (frac >= DATA_W - 1) begin
            v = 16'sh7FFF;
        end else begin
            v = 16'sd1 << frac;
        end
        return v;
    endfunction

endpackage

// ===== hdl/lpe_datapath.sv =====
// ============================================================================
// Legendre evaluator datapath
// Shared multiplier, accumulator, recurrence registers and reciprocal table,
// driven one control word per cycle by the microcode sequencer.
// ============================================================================
module lpe_datapath #(
    parameter int MAX_DEGREE = lpe_pkg::MAX_DEGREE,
    parameter int FRAC_BITS  = lpe_pkg::FRAC_BITS,
    parameter int KW         = $clog2(MAX_DEGREE + 1)
) (
    input  logic                              i_clk,
    input  lpe_pkg::t_ctrl                    i_ctrl,
    input  logic                              i_load,
    input  logic signed [lpe_pkg::DATA_W-1:0] i_x,
    input  logic [KW-1:0]                     i_k,
    output lpe_pkg::t_dp_stat                 o_stat
);

    localparam int DW    = lpe_pkg::DATA_W;
    localparam int RB    = lpe_pkg::RECIP_BITS;
    localparam int ODD_W = KW + 1;
    localparam int T_W   = 2 * DW + ODD_W + 1 - FRAC_BITS;
    localparam int U_W   = DW + KW + 1;
    localparam int S_W   = ((T_W > U_W) ? T_W : U_W) + 1;
    localparam int A_W   = (S_W > 2 * DW) ? S_W : 2 * DW;
    localparam int B_W0  = (RB + 1 > DW) ? RB + 1 : DW;
    localparam int B_W   = (B_W0 > ODD_W + 1) ? B_W0 : ODD_W + 1;
    localparam int P_W   = A_W + B_W;

    localparam logic signed [P_W-1:0] HALF = P_W'(1) << (RB - 1);
    localparam logic signed [P_W-1:0] MAXV = P_W'(32767);
    localparam logic signed [P_W-1:0] MINV = P_W'(-32768);

    logic signed [P_W-1:0] r_acc;
    logic signed [P_W-1:0] n_acc;
    logic signed [DW-1:0]  r_x;
    logic signed [DW-1:0]  r_p1;
    logic signed [DW-1:0]  r_p2;
    logic                  r_flag;

    logic [RB-1:0]         w_recip [0:MAX_DEGREE];
    logic [ODD_W-1:0]      w_odd;
    logic [KW-1:0]         w_km1;
    logic signed [A_W-1:0] w_a;
    logic signed [B_W-1:0] w_b;
    logic signed [P_W-1:0] w_prod;
    logic signed [P_W-1:0] w_q;
    logic signed [DW-1:0]  w_clip;
    logic                  w_sat;

    // Reciprocal table: 1/k rounded to nearest, RECIP_BITS fraction bits.
    assign w_recip[0] = '0;
    assign w_recip[1] = '0;
    for (genvar g = 2; g <= MAX_DEGREE; g++) begin : g_recip
        localparam logic [RB-1:0] RV = RB'(((longint'(1) << RB) + g / 2) / g);
        assign w_recip[g] = RV;
    end

    // Step-dependent coefficients 2k-1 and k-1.
    assign w_odd = {i_k, 1'b0} - ODD_W'(1);
    assign w_km1 = i_k - KW'(1);

    // Operand selection for the shared multiplier.
    always_comb begin
        case (i_ctrl.asel)
            lpe_pkg::A_X:   w_a = A_W'(r_x);
            lpe_pkg::A_ACC: w_a = r_acc[A_W-1:0];
            lpe_pkg::A_P2:  w_a = A_W'(r_p2);
            default:        w_a = '0;
        endcase
        case (i_ctrl.bsel)
            lpe_pkg::B_P1:    w_b = B_W'(r_p1);
            lpe_pkg::B_ODD:   w_b = B_W'(w_odd);
            lpe_pkg::B_KM1:   w_b = B_W'(w_km1);
            lpe_pkg::B_RECIP: w_b = B_W'(w_recip[i_k]);
            default:          w_b = '0;
        endcase
    end

    assign w_prod = w_a * w_b;

    // Accumulator update.
    always_comb begin
        case (i_ctrl.accop)
            lpe_pkg::ACC_MUL: n_acc = w_prod;
            lpe_pkg::ACC_SUB: n_acc = (r_acc >>> FRAC_BITS) - w_prod;
            lpe_pkg::ACC_RND: n_acc = w_prod + HALF;
            default:          n_acc = r_acc;
        endcase
    end

    // Drop the reciprocal fraction and clip to the 16-bit range.
    always_comb begin
        w_q = r_acc >>> RB;
        if (w_q > MAXV) begin
            w_clip = 16'sh7FFF;
            w_sat  = 1'b1;
        end else if (w_q < MINV) begin
            w_clip = -16'sh8000;
            w_sat  = 1'b1;
        end else begin
            w_clip = w_q[DW-1:0];
            w_sat  = 1'b0;
        end
    end

    // Recurrence registers: P_k-1, P_k-2, the argument and the clip flag.
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (i_load) begin
            r_x    <= i_x;
            r_p1   <= i_x;
            r_p2   <= lpe_pkg::one_value(FRAC_BITS);
            r_flag <= lpe_pkg::one_sat(FRAC_BITS);
        end else if (i_ctrl.wb) begin
            r_p2   <= r_p1;
            r_p1   <= w_clip;
            r_flag <= r_flag | w_sat;
        end
    end

    assign o_stat.value = w_clip;
    assign o_stat.sat   = r_flag | w_sat;

endmodule

// ===== hdl/legendre_polynomial_eval.sv =====
// ============================================================================
// Legendre polynomial evaluator
// Computes P_n(x) in signed fixed point with the Bonnet recurrence, using a
// microcoded sequencer over a single shared multiplier.
// ============================================================================
// Usage:
//   Command channel: start with i_degree and i_x_value is taken at a rising
//   edge where start is high and busy is low. The degree is clamped to
//   MAX_DEGREE.
//   Result channel: o_done is high for one cycle with o_poly_value and
//   o_saturated; the receiver takes it in that cycle and cannot stall it.
//   Timing: degree 0 or 1 gives its result in the cycle after the transfer
//   and busy stays low. Degree n >= 2 runs n-1 recurrence steps of five
//   microcode words each on the shared multiplier while busy is high, and
//   the result shows in the cycle in which busy falls.
//   A new item can be given in the cycle the result is shown.
//   Reset clears the sequencer, busy and the result strobe; an item in
//   flight is dropped.
// ============================================================================
module legendre_polynomial_eval #(
    parameter int MAX_DEGREE = lpe_pkg::MAX_DEGREE,
    parameter int FRAC_BITS  = lpe_pkg::FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic [lpe_pkg::DEG_W-1:0]         i_degree,
    input  logic signed [lpe_pkg::DATA_W-1:0] i_x_value,
    output logic                              busy,
    output logic                              o_done,
    output logic signed [lpe_pkg::DATA_W-1:0] o_poly_value,
    output logic                              o_saturated
);

    localparam int KW = $clog2(MAX_DEGREE + 1);
    localparam int NW = (KW > lpe_pkg::DEG_W) ? KW : lpe_pkg::DEG_W;

    logic                              r_busy;
    logic                              n_busy;
    logic [lpe_pkg::PC_W-1:0]          r_pc;
    logic [lpe_pkg::PC_W-1:0]          n_pc;
    logic [KW-1:0]                     r_k;
    logic [KW-1:0]                     n_k;
    logic [KW-1:0]                     r_n;
    logic [KW-1:0]                     n_n;
    logic                              r_done;
    logic                              n_done;
    logic signed [lpe_pkg::DATA_W-1:0] r_poly;
    logic signed [lpe_pkg::DATA_W-1:0] n_poly;
    logic                              r_sat;
    logic                              n_sat;

    logic                              w_accept;
    logic [NW-1:0]                     w_deg_ext;
    logic [KW-1:0]                     w_n;
    lpe_pkg::t_ctrl                    w_ucode;
    lpe_pkg::t_ctrl                    w_ctrl;
    lpe_pkg::t_dp_stat                 w_stat;

    assign w_accept = start & ~r_busy;

    // Degree clamp.
    assign w_deg_ext = NW'(i_degree);
    assign w_n = (w_deg_ext > NW'(MAX_DEGREE)) ? KW'(MAX_DEGREE) : KW'(w_deg_ext);

    // Microcode fetch; the datapath idles while no item is in work.
    assign w_ucode = lpe_pkg::ucode(r_pc);
    assign w_ctrl  = r_busy ? w_ucode : lpe_pkg::CTRL_NOP;

    lpe_datapath #(
        .MAX_DEGREE (MAX_DEGREE),
        .FRAC_BITS  (FRAC_BITS),
        .KW         (KW)
    ) u_datapath (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .i_load (w_accept),
        .i_x    (i_x_value),
        .i_k    (r_k),
        .o_stat (w_stat)
    );

    // Sequencer: command transfer, step counter and loop jump.
    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        n_k    = r_k;
        n_n    = r_n;
        n_done = 1'b0;
        n_poly = r_poly;
        n_sat  = r_sat;
        if (!r_busy) begin
            if (start) begin
                if (w_n < KW'(2)) begin
                    n_done = 1'b1;
                    n_poly = (w_n == KW'(0)) ? lpe_pkg::one_value(FRAC_BITS) : i_x_value;
                    n_sat  = lpe_pkg::one_sat(FRAC_BITS);
                end else begin
                    n_busy = 1'b1;
                    n_pc   = lpe_pkg::PC_MUL_XP;
                    n_k    = KW'(2);
                    n_n    = w_n;
                end
            end
        end else begin
            case (w_ucode.jump)
                lpe_pkg::J_LOOP: begin
                    if (r_k == r_n) begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                        n_poly = w_stat.value;
                        n_sat  = w_stat.sat;
                    end else begin
                        n_pc = lpe_pkg::PC_MUL_XP;
                        n_k  = r_k + KW'(1);
                    end
                end
                default: begin
                    n_pc = r_pc + lpe_pkg::PC_W'(1);
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= lpe_pkg::PC_MUL_XP;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
            r_done <= n_done;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_n    <= n_n;
        r_poly <= n_poly;
        r_sat  <= n_sat;
    end

    assign busy         = r_busy;
    assign o_done       = r_done;
    assign o_poly_value = r_poly;
    assign o_saturated  = r_sat;

endmodule

// ===== hdl/lpe_checker.sv =====
// ============================================================================
// Legendre evaluator port checker
// Watches the command and result ports of the evaluator over time.
// ============================================================================
module lpe_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic [lpe_pkg::DEG_W-1:0]         i_degree,
    input logic signed [lpe_pkg::DATA_W-1:0] i_x_value,
    input logic                              busy,
    input logic                              o_done,
    input logic signed [lpe_pkg::DATA_W-1:0] o_poly_value,
    input logic                              o_saturated
);

    // A degree of two or more keeps the block busy after the transfer.
    a_long_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_degree >= 5'd2) |=> busy)
        else $error("busy not raised for a recurrence item");

    // Degree zero or one answers in the next cycle without going busy.
    a_short_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_degree < 5'd2) |=> (o_done && !busy))
        else $error("short item did not answer at once");

    // Busy only drops when a result is shown.
    a_fall_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_done)
        else $error("busy fell without a result");

    // The result fields carry defined values whenever the strobe is high.
    a_done_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!$isunknown(o_poly_value) && !$isunknown(o_saturated)))
        else $error("result fields unknown during the strobe");

endmodule

bind legendre_polynomial_eval lpe_checker u_lpe_checker (.*);
